/* src/slt_pkg.sv */
// Shared types and constants for the shared/exclusive lock table.
// Used by slt_front, slt_engine, slt_rsp_queue and the core top level.
package slt_pkg;

  localparam int unsigned ENTRIES = 64;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned RES_W   = 32;
  localparam int unsigned TXN_W   = 32;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOT_HELD = 2'd3
  } status_e;

  typedef enum logic {
    OP_LOCK   = 1'b0,
    OP_UNLOCK = 1'b1
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [RES_W-1:0] resource_id;
    logic [TXN_W-1:0] txn_id;
    logic             exclusive_mode;
  } cmd_t;

  typedef struct packed {
    logic    success;
    status_e status;
  } rsp_t;

endpackage

/* src/slt_front.sv */
// Request front end: decodes incoming words into commands and buffers two of them.
// Depends on slt_pkg.
module slt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic              req_type_i,
  input  logic [31:0]       resource_id_i,
  input  logic [31:0]       txn_id_i,
  input  logic              exclusive_mode_i,
  output slt_pkg::cmd_t     cmd_o,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i
);
  import slt_pkg::*;

  cmd_t       buf_q [2];
  cmd_t       in_cmd;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  // Classify: unlock carries no mode
  always_comb begin
    in_cmd.op             = req_type_i ? OP_UNLOCK : OP_LOCK;
    in_cmd.resource_id    = resource_id_i;
    in_cmd.txn_id         = txn_id_i;
    in_cmd.exclusive_mode = exclusive_mode_i & ~req_type_i;
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = buf_q[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en) rd_ptr_q <= ~rd_ptr_q;
      case ({wr_en, rd_en})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) buf_q[wr_ptr_q] <= in_cmd;
  end

endmodule

/* src/slt_engine.sv */
// Lock table engine: slot memory, valid bits and the one-slot-per-cycle scan.
// Depends on slt_pkg.
module slt_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  slt_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  output slt_pkg::rsp_t rsp_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i
);
  import slt_pkg::*;

  typedef enum logic [1:0] {
    E_IDLE,
    E_SCAN,
    E_RESP
  } state_e;

  typedef struct packed {
    logic [RES_W-1:0] resource_id;
    logic [TXN_W-1:0] txn_id;
    logic             exclusive_mode;
  } slot_t;

  slot_t              slot_mem [ENTRIES];
  slot_t              rd_data_q;
  logic [ENTRIES-1:0] slot_valid_q;

  state_e             state_q;
  cmd_t               cmd_q;
  logic [CNT_W-1:0]   issue_q;
  logic               chk_vld_q;
  logic               chk_valid_q;
  logic [IDX_W-1:0]   chk_idx_q;
  logic               free_found_q;
  logic [IDX_W-1:0]   free_idx_q;
  rsp_t               rsp_q;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_idx;
  logic               res_hit, lock_conflict, unlock_hit, chk_last, free_any, finish;
  logic [IDX_W-1:0]   free_slot;
  logic               mem_we;
  rsp_t               rsp_d;

  assign cmd_ready_o = (state_q == E_IDLE);
  assign rsp_valid_o = (state_q == E_RESP);
  assign rsp_o       = rsp_q;

  assign rd_idx = issue_q[IDX_W-1:0];
  assign rd_en  = (state_q == E_SCAN) && (issue_q < CNT_W'(ENTRIES));

  // Check the slot read last cycle against the held command
  always_comb begin
    res_hit       = chk_valid_q && (rd_data_q.resource_id == cmd_q.resource_id);
    lock_conflict = (cmd_q.op == OP_LOCK) && res_hit &&
                    (rd_data_q.exclusive_mode || cmd_q.exclusive_mode);
    unlock_hit    = (cmd_q.op == OP_UNLOCK) && res_hit &&
                    (rd_data_q.txn_id == cmd_q.txn_id);
    chk_last      = (chk_idx_q == IDX_W'(ENTRIES - 1));
    free_any      = free_found_q || !chk_valid_q;
    free_slot     = free_found_q ? free_idx_q : chk_idx_q;
    finish        = (state_q == E_SCAN) && chk_vld_q &&
                    (lock_conflict || unlock_hit || chk_last);
    mem_we        = finish && (cmd_q.op == OP_LOCK) && !lock_conflict && free_any;

    // Conflict wins over table full
    if (lock_conflict) begin
      rsp_d = '{success: 1'b0, status: ST_CONFLICT};
    end else if (unlock_hit) begin
      rsp_d = '{success: 1'b1, status: ST_OK};
    end else if (cmd_q.op == OP_UNLOCK) begin
      rsp_d = '{success: 1'b0, status: ST_NOT_HELD};
    end else if (free_any) begin
      rsp_d = '{success: 1'b1, status: ST_OK};
    end else begin
      rsp_d = '{success: 1'b0, status: ST_FULL};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= E_IDLE;
      issue_q      <= '0;
      chk_vld_q    <= 1'b0;
      chk_valid_q  <= 1'b0;
      free_found_q <= 1'b0;
      slot_valid_q <= '0;
      rsp_q        <= '{success: 1'b0, status: ST_OK};
    end else begin
      case (state_q)
        E_IDLE: begin
          if (cmd_valid_i) begin
            issue_q      <= '0;
            chk_vld_q    <= 1'b0;
            free_found_q <= 1'b0;
            state_q      <= E_SCAN;
          end
        end
        E_SCAN: begin
          if (rd_en) begin
            issue_q     <= issue_q + CNT_W'(1);
            chk_valid_q <= slot_valid_q[rd_idx];
          end
          chk_vld_q <= rd_en;
          if (chk_vld_q && !chk_valid_q) free_found_q <= 1'b1;
          if (finish) begin
            rsp_q     <= rsp_d;
            chk_vld_q <= 1'b0;
            state_q   <= E_RESP;
            if (mem_we) slot_valid_q[free_slot] <= 1'b1;
            if (unlock_hit) slot_valid_q[chk_idx_q] <= 1'b0;
          end
        end
        E_RESP: begin
          if (rsp_ready_i) state_q <= E_IDLE;
        end
        default: state_q <= E_IDLE;
      endcase
    end
  end

  // Scan bookkeeping that needs no reset
  always_ff @(posedge clk_i) begin
    if (state_q == E_IDLE && cmd_valid_i) cmd_q <= cmd_i;
    if (rd_en) chk_idx_q <= rd_idx;
    if (chk_vld_q && !chk_valid_q && !free_found_q) free_idx_q <= chk_idx_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[free_slot] <= '{resource_id:    cmd_q.resource_id,
                               txn_id:         cmd_q.txn_id,
                               exclusive_mode: cmd_q.exclusive_mode};
    end
    if (rd_en) rd_data_q <= slot_mem[rd_idx];
  end

endmodule

/* src/slt_rsp_queue.sv */
// Two-word result queue between the engine and the output ports.
// Depends on slt_pkg.
module slt_rsp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  slt_pkg::rsp_t rsp_i,
  input  logic          rsp_valid_i,
  output logic          rsp_ready_o,
  output slt_pkg::rsp_t rsp_o,
  output logic          empty_o,
  input  logic          pop_i
);
  import slt_pkg::*;

  rsp_t       buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  assign rsp_ready_o = (cnt_q != 2'd2);
  assign empty_o     = (cnt_q == 2'd0);
  assign rsp_o       = buf_q[rd_ptr_q];
  assign wr_en       = rsp_valid_i && rsp_ready_o;
  assign rd_en       = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en) rd_ptr_q <= ~rd_ptr_q;
      case ({wr_en, rd_en})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) buf_q[wr_ptr_q] <= rsp_i;
  end

endmodule

/* src/shared_exclusive_lock_table_core.sv */
// Shared/exclusive lock table with 64 slots (slt_pkg::ENTRIES). Requests enter through a
// two-word queue (push/full) and results leave through a two-word queue (empty/pop), one
// result per request, in order. The engine handles one request at a time and walks the slot
// memory one slot per cycle through its single read port: a full scan visits all ENTRIES
// slots, while a lock that conflicts or an unlock that finds its holder stops early, at that
// slot. A granted lock takes the lowest free slot; an unlock frees the lowest slot matching
// resource and transaction. Valid bits clear at reset, so the table is usable right away.
// Depends on slt_pkg, slt_front, slt_engine, slt_rsp_queue.
module shared_exclusive_lock_table_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        req_type_i,
  input  logic [31:0] resource_id_i,
  input  logic [31:0] txn_id_i,
  input  logic        exclusive_mode_i,
  output logic        empty,
  input  logic        pop,
  output logic        success_o,
  output logic [1:0]  status_o
);
  import slt_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;
  rsp_t eng_rsp, out_rsp;
  logic rsp_valid, rsp_ready;

  slt_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_o           (full),
    .req_type_i       (req_type_i),
    .resource_id_i    (resource_id_i),
    .txn_id_i         (txn_id_i),
    .exclusive_mode_i (exclusive_mode_i),
    .cmd_o            (cmd),
    .cmd_valid_o      (cmd_valid),
    .cmd_ready_i      (cmd_ready)
  );

  slt_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .rsp_o       (eng_rsp),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready)
  );

  slt_rsp_queue u_rsp_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rsp_i       (eng_rsp),
    .rsp_valid_i (rsp_valid),
    .rsp_ready_o (rsp_ready),
    .rsp_o       (out_rsp),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  assign success_o = out_rsp.success;
  assign status_o  = out_rsp.status;

  // Success and status ok agree whenever the reply queue is not empty
  a_success_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (success_o == (status_o == ST_OK)))
    else $error("success and status disagree");

  // Engine takes no new command while it holds a result
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready) |-> !rsp_valid)
    else $error("command taken while result pending");

  // Handing off a result returns the engine to idle
  a_idle_after_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && rsp_ready) |=> (!rsp_valid && cmd_ready))
    else $error("engine not idle after result handoff");

endmodule

/* bench/lock_reply_checker.sv */
// Watches both queue ports of the lock table, keeps a shadow table of held locks and
// checks every reply word against it. Depends on slt_pkg for the request and reply types.
module lock_reply_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic        req_type_i,
  input  logic [31:0] resource_id_i,
  input  logic [31:0] txn_id_i,
  input  logic        exclusive_mode_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic        success_i,
  input  logic [1:0]  status_i,
  output int          fail_count_o,
  output int          owed_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import slt_pkg::*;

  logic             held      [ENTRIES];
  logic [RES_W-1:0] held_res  [ENTRIES];
  logic [TXN_W-1:0] held_txn  [ENTRIES];
  logic             held_excl [ENTRIES];

  rsp_t owed_replies [$];
  int   fails;

  // Apply one request to the shadow table and return the reply it earns.
  function automatic rsp_t grant_or_refuse(cmd_t req);
    int   free_idx;
    rsp_t reply;
    free_idx      = -1;
    reply.success = 1'b0;
    reply.status  = ST_OK;
    if (req.op == OP_UNLOCK) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (held[i] && held_res[i] == req.resource_id && held_txn[i] == req.txn_id) begin
          held[i]       = 1'b0;
          reply.success = 1'b1;
          return reply;
        end
      end
      reply.status = ST_NOT_HELD;
      return reply;
    end
    // Conflict wins over a full table, so scan every slot before giving up.
    for (int i = 0; i < ENTRIES; i++) begin
      if (held[i]) begin
        if (held_res[i] == req.resource_id && (held_excl[i] || req.exclusive_mode)) begin
          reply.status = ST_CONFLICT;
          return reply;
        end
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (free_idx < 0) begin
      reply.status = ST_FULL;
      return reply;
    end
    held[free_idx]      = 1'b1;
    held_res[free_idx]  = req.resource_id;
    held_txn[free_idx]  = req.txn_id;
    held_excl[free_idx] = req.exclusive_mode;
    reply.success       = 1'b1;
    return reply;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t req;
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) held[i] = 1'b0;
      owed_replies.delete();
      fails = 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (owed_replies.size() == 0) begin
          fails++;
          $display("%0t: unexpected reply word: expected none, got success %0b status %0d",
                   $time, success_i, status_i);
        end else begin
          want = owed_replies.pop_front();
          if (success_i !== want.success) begin
            fails++;
            $display("%0t: success mismatch: expected %0b, got %0b",
                     $time, want.success, success_i);
          end
          if (status_i !== want.status) begin
            fails++;
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, status_i);
          end
        end
      end
      if (push_i && !full_i) begin
        req.op             = op_e'(req_type_i);
        req.resource_id    = resource_id_i;
        req.txn_id         = txn_id_i;
        req.exclusive_mode = exclusive_mode_i;
        owed_replies.insert(owed_replies.size(), grant_or_refuse(req));
      end
    end
    fail_count_o <= fails;
    owed_count_o <= owed_replies.size();
  end

endmodule

/* bench/shared_exclusive_lock_table_core_tb.sv */
// Top of the lock table bench: clock, reset, request and reply traffic, watchdog and verdict.
// Depends on slt_pkg, shared_exclusive_lock_table_core and lock_reply_checker.
module shared_exclusive_lock_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slt_pkg::*;

  localparam int ITEM_GOAL       = 1800;
  localparam int QUIET_LIMIT     = 3000;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int DRAIN_CYCLES    = 100;
  localparam int LENT_MAX        = 96;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic        req_type;
  logic [31:0] resource_id;
  logic [31:0] txn_id;
  logic        excl;
  logic        empty;
  logic        pop;
  logic        success;
  logic [1:0]  status;
  int          fail_count;
  int          owed_count;

  int          send_idle_pct;
  int          pop_stall_pct;
  bit          hold_go;
  int          words_sent;
  logic [31:0] lent_res [$];
  logic [31:0] lent_txn [$];

  shared_exclusive_lock_table_core u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .push             (push),
    .full             (full),
    .req_type_i       (req_type),
    .resource_id_i    (resource_id),
    .txn_id_i         (txn_id),
    .exclusive_mode_i (excl),
    .empty            (empty),
    .pop              (pop),
    .success_o        (success),
    .status_o         (status)
  );

  lock_reply_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .push_i           (push),
    .full_i           (full),
    .req_type_i       (req_type),
    .resource_id_i    (resource_id),
    .txn_id_i         (txn_id),
    .exclusive_mode_i (excl),
    .empty_i          (empty),
    .pop_i            (pop),
    .success_i        (success),
    .status_i         (status),
    .fail_count_o     (fail_count),
    .owed_count_o     (owed_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly a handful of hot ids so that requests collide, with the extremes mixed in.
  function automatic logic [31:0] pick_res();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return $urandom_range(4);
      6:                return 32'hFFFF_FFFF;
      default:          return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_txn();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5, 6: return $urandom_range(3);
      7:                   return 32'hFFFF_FFFF;
      default:             return $urandom;
    endcase
  endfunction

  // Leave push high on return so back-to-back words need no second assignment.
  task automatic offer(op_e op, logic [31:0] res, logic [31:0] txn, logic mode);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    push        <= 1'b1;
    req_type    <= op;
    resource_id <= res;
    txn_id      <= txn;
    excl        <= mode;
    @(posedge clk);
    while (full) @(posedge clk);
    words_sent++;
  endtask

  task automatic request_lock(logic [31:0] res, logic [31:0] txn, logic mode);
    offer(OP_LOCK, res, txn, mode);
    lent_res.insert(lent_res.size(), res);
    lent_txn.insert(lent_txn.size(), txn);
    if (lent_res.size() > LENT_MAX) begin
      void'(lent_res.pop_front());
      void'(lent_txn.pop_front());
    end
  endtask

  task automatic release_some();
    int          k;
    logic [31:0] res;
    logic [31:0] txn;
    if (lent_res.size() > 0 && $urandom_range(4) != 0) begin
      k   = $urandom_range(lent_res.size() - 1);
      res = lent_res[k];
      txn = lent_txn[k];
      lent_res.delete(k);
      lent_txn.delete(k);
      offer(OP_UNLOCK, res, txn, 1'($urandom_range(1)));
    end else begin
      offer(OP_UNLOCK, pick_res(), pick_txn(), 1'($urandom_range(1)));
    end
  endtask

  // Pile shared holders onto one id until the table runs out, probe conflict and full,
  // then free every holder again.
  task automatic fill_table();
    logic [31:0] hot;
    logic [31:0] base;
    hot  = $urandom;
    base = $urandom;
    for (int n = 0; n < ENTRIES + 2; n++) offer(OP_LOCK, hot, base + n, 1'b0);
    offer(OP_LOCK, hot, $urandom, 1'b1);
    offer(OP_LOCK, hot, base, 1'b0);
    for (int n = 0; n < ENTRIES + 2; n++)
      offer(OP_UNLOCK, hot, base + n, 1'($urandom_range(1)));
    offer(OP_UNLOCK, hot, base, 1'b0);
  endtask

  task automatic run_directed();
    offer(OP_LOCK,   32'h0,         32'h0,         1'b0);
    offer(OP_LOCK,   32'h0,         32'h1,         1'b0);
    offer(OP_LOCK,   32'h0,         32'h0,         1'b0);
    offer(OP_LOCK,   32'h0,         32'h0,         1'b1);
    offer(OP_UNLOCK, 32'h0,         32'h0,         1'b0);
    offer(OP_UNLOCK, 32'h0,         32'h0,         1'b1);
    offer(OP_UNLOCK, 32'h0,         32'h0,         1'b0);
    offer(OP_UNLOCK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    offer(OP_LOCK,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    offer(OP_LOCK,   32'hFFFF_FFFF, 32'h0,         1'b0);
    offer(OP_LOCK,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    offer(OP_UNLOCK, 32'hFFFF_FFFF, 32'h0,         1'b1);
    offer(OP_UNLOCK, 32'h0,         32'h1,         1'b0);
    offer(OP_UNLOCK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    fill_table();
  endtask

  task automatic run_episode();
    int pick;
    pick = $urandom_range(99);
    if (pick < 3) begin
      fill_table();
    end else if (pick < 13) begin
      while (lent_res.size() > 0)
        offer(OP_UNLOCK, lent_res.pop_front(), lent_txn.pop_front(), 1'($urandom_range(1)));
    end else if (pick < 23) begin
      repeat (8) offer(op_e'($urandom_range(1)), $urandom, $urandom, 1'($urandom_range(1)));
    end else begin
      repeat (16) begin
        if ($urandom_range(1)) request_lock(pick_res(), pick_txn(), $urandom_range(9) < 3);
        else release_some();
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    push          = 1'b0;
    req_type      = OP_LOCK;
    resource_id   = '0;
    txn_id        = '0;
    excl          = 1'b0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_go       = 1'b0;
    words_sent    = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1:       begin send_idle_pct = 78; pop_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  pop_stall_pct = 78; end
        3:       begin send_idle_pct = 21; pop_stall_pct = 21; end
        default: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
      endcase
      if (ph == 0) begin
        run_directed();
        // Stop draining replies while requests keep coming, so the input backs up.
        hold_go = 1'b1;
      end
      while (words_sent < (ph + 1) * ITEM_GOAL / 5) run_episode();
    end

    push <= 1'b0;
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    int held_off;
    bit hold_done;
    held_off  = 0;
    hold_done = 1'b0;
    pop       = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        pop <= 1'b0;
        held_off++;
        if (held_off == HOLD_OFF_CYCLES) hold_done = 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst_n && !((push && !full) || (pop && !empty))) quiet++;
      else quiet = 0;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule
